### rtl/core/ansi_sgr_color_parser_core_defines.svh
// Assertion macros shared by the ANSI SGR color parser RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ANSI_SGR_COLOR_PARSER_CORE_DEFINES_SVH
`define ANSI_SGR_COLOR_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ascp_pkg.sv
// Package for the ANSI SGR color parser: character codes, color constants,
// the job descriptor type and the SGR code application function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ascp_pkg;

    localparam logic [7:0] ESC_CHAR  = 8'h1B;
    localparam logic [7:0] LBRACKET  = 8'h5B;
    localparam logic [7:0] SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_M    = 8'h6D;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;

    localparam logic [15:0] GRAY      = 16'h0700;
    localparam logic [15:0] BRIGHT_FG = 16'h0800;
    localparam logic [15:0] SWAP_MASK = 16'hFF00;
    localparam logic [15:0] KEEP_BG   = 16'hF000;
    localparam logic [15:0] KEEP_FG   = 16'h0F00;
    localparam logic [15:0] BRIGHT_BG = 16'h8000;

    localparam logic [7:0] ACCUM_MAX = 8'd255;

    // Held byte count carried in a job; covers the largest buffer length (32).
    localparam int HELD_W = 5;

    // Console color index to attribute nibble.
    localparam logic [2:0] CMAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    // SGR code values
    localparam logic [7:0] SGR_RESET  = 8'd0;
    localparam logic [7:0] SGR_BRIGHT = 8'd1;
    localparam logic [7:0] SGR_DIM    = 8'd2;
    localparam logic [7:0] SGR_SWAP   = 8'd7;
    localparam logic [7:0] SGR_FG     = 8'd30;
    localparam logic [7:0] SGR_BG     = 8'd40;
    localparam logic [7:0] SGR_FG_HI  = 8'd90;
    localparam logic [7:0] SGR_BG_HI  = 8'd100;
    localparam logic [7:0] SGR_SPAN   = 8'd7;

    // One unit of work for the emitter: held bytes, then the tail character.
    typedef struct packed {
        logic [HELD_W-1:0] held;
        logic [7:0]        tail;
        logic [15:0]       color;
    } job_meta_t;

    function automatic logic [15:0] apply_code(input logic [15:0] col,
                                               input logic [7:0]  code);
        logic [15:0] r;
        logic [7:0]  off_fg;
        logic [7:0]  off_bg;
        logic [7:0]  off_fh;
        logic [7:0]  off_bh;
        r      = col;
        off_fg = code - SGR_FG;
        off_bg = code - SGR_BG;
        off_fh = code - SGR_FG_HI;
        off_bh = code - SGR_BG_HI;
        if (code == SGR_RESET) begin
            r = GRAY;
        end else if (code == SGR_BRIGHT) begin
            r = col | BRIGHT_FG;
        end else if (code == SGR_DIM) begin
            r = col & ~BRIGHT_FG;
        end else if (code == SGR_SWAP) begin
            r = {col[11:8], col[15:12] | col[7:4], 8'h00} & SWAP_MASK;
        end else if (code >= SGR_FG && code <= SGR_FG + SGR_SPAN) begin
            r = (col & KEEP_BG) | {5'd0, CMAP[off_fg[2:0]], 8'h00};
        end else if (code >= SGR_BG && code <= SGR_BG + SGR_SPAN) begin
            r = (col & KEEP_FG) | {1'b0, CMAP[off_bg[2:0]], 12'h000};
        end else if (code >= SGR_FG_HI && code <= SGR_FG_HI + SGR_SPAN) begin
            r = (col & KEEP_BG) | {5'd0, CMAP[off_fh[2:0]], 8'h00} | BRIGHT_FG;
        end else if (code >= SGR_BG_HI && code <= SGR_BG_HI + SGR_SPAN) begin
            r = (col & KEEP_FG) | {1'b0, CMAP[off_bh[2:0]], 12'h000} | BRIGHT_BG;
        end
        return r;
    endfunction

    // Fold one decimal digit into the code, saturating at 255.
    function automatic logic [7:0] accum_digit(input logic [7:0] acc,
                                               input logic [7:0] ch);
        logic [11:0] sum;
        sum = ({4'd0, acc} * 12'd10) + {4'd0, ch - CHAR_0};
        return (sum > {4'd0, ACCUM_MAX}) ? ACCUM_MAX : sum[7:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/ascp_front.sv
// Front end of the ANSI SGR color parser: classifies each request, tracks the
// escape sequence state and colors, and issues emit jobs. Depends on ascp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ascp_front #(
    parameter int BUF_LEN = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic                     job_full,
    input  wire logic                     cmd,
    input  wire logic [7:0]               char_byte,
    input  wire logic [15:0]              color_value,
    output logic                          job_push,
    output ascp_pkg::job_meta_t           job_meta,
    output logic [BUF_LEN*8-1:0]          job_bytes
);

    localparam int CNT_W = $clog2(BUF_LEN + 1);
    localparam int IDX_W = $clog2(BUF_LEN);
    localparam int HW    = ascp_pkg::HELD_W;

    typedef enum logic [2:0] {
        K_COLOR,
        K_PLAIN,
        K_START,
        K_OPEN,
        K_DIGIT,
        K_SEP,
        K_CLOSE,
        K_FLUSH
    } kind_t;

    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [7:0]       accum_reg, accum_next;
    logic [15:0]      pending_reg, pending_next;
    logic [15:0]      current_reg, current_next;
    logic [7:0]       held_reg [BUF_LEN];

    logic             accept;
    kind_t            kind;
    logic [CNT_W-1:0] len;
    logic             is_digit;
    logic             body_ok;

    assign accept   = push && !job_full;
    assign len      = held_count_reg + CNT_W'(1);
    assign is_digit = (char_byte >= ascp_pkg::CHAR_0) && (char_byte <= ascp_pkg::CHAR_9);
    assign body_ok  = (len > CNT_W'(2)) && (len < CNT_W'(BUF_LEN));

    always_comb
    begin
        if (cmd) begin
            kind = K_COLOR;
        end else if (held_count_reg == '0 || held_count_reg >= CNT_W'(BUF_LEN)) begin
            kind = (char_byte == ascp_pkg::ESC_CHAR) ? K_START : K_PLAIN;
        end else if (len == CNT_W'(2) && char_byte == ascp_pkg::LBRACKET) begin
            kind = K_OPEN;
        end else if (body_ok && is_digit) begin
            kind = K_DIGIT;
        end else if (body_ok && char_byte == ascp_pkg::SEMICOLON) begin
            kind = K_SEP;
        end else if (char_byte == ascp_pkg::CHAR_M) begin
            kind = K_CLOSE;
        end else begin
            kind = K_FLUSH;
        end
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        accum_next      = accum_reg;
        pending_next    = pending_reg;
        current_next    = current_reg;
        if (accept) begin
            unique case (kind)
                K_COLOR: current_next = color_value;
                K_PLAIN:
                begin
                    held_count_next = '0;
                    accum_next      = '0;
                end
                K_START:
                begin
                    held_count_next = CNT_W'(1);
                    accum_next      = '0;
                end
                K_OPEN:
                begin
                    pending_next    = ascp_pkg::GRAY;
                    accum_next      = '0;
                    held_count_next = len;
                end
                K_DIGIT:
                begin
                    accum_next      = ascp_pkg::accum_digit(accum_reg, char_byte);
                    held_count_next = len;
                end
                K_SEP:
                begin
                    pending_next    = ascp_pkg::apply_code(pending_reg, accum_reg);
                    accum_next      = '0;
                    held_count_next = len;
                end
                K_CLOSE:
                begin
                    // "ESC m" alone falls back to gray
                    current_next    = (len == CNT_W'(2)) ? ascp_pkg::GRAY
                                    : ascp_pkg::apply_code(pending_reg, accum_reg);
                    held_count_next = '0;
                    accum_next      = '0;
                end
                K_FLUSH:
                begin
                    held_count_next = '0;
                    accum_next      = '0;
                end
                default:
                begin
                    held_count_next = held_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_count_reg <= '0;
            accum_reg      <= '0;
            pending_reg    <= ascp_pkg::GRAY;
            current_reg    <= ascp_pkg::GRAY;
        end else begin
            held_count_reg <= held_count_next;
            accum_reg      <= accum_next;
            pending_reg    <= pending_next;
            current_reg    <= current_next;
        end
    end

    // Hold sequence bytes; only entries below the count are ever read.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            if (kind == K_START) begin
                held_reg[0] <= char_byte;
            end else if (kind == K_OPEN || kind == K_DIGIT || kind == K_SEP) begin
                held_reg[held_count_reg[IDX_W-1:0]] <= char_byte;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < BUF_LEN; i++) begin
            job_bytes[i*8 +: 8] = held_reg[i];
        end
    end

    assign job_push       = accept && (kind == K_PLAIN || kind == K_FLUSH);
    assign job_meta.held  = (kind == K_FLUSH) ? HW'(held_count_reg) : '0;
    assign job_meta.tail  = char_byte;
    assign job_meta.color = current_reg;

endmodule

`default_nettype wire

### rtl/core/ascp_job_fifo.sv
// Two-entry job queue between the parser front end and the emitter.
// Depends on ascp_pkg for the job descriptor type.
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_sgr_color_parser_core_defines.svh"

module ascp_job_fifo #(
    parameter int BYTES_W = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  ascp_pkg::job_meta_t      wr_meta,
    input  wire logic [BYTES_W-1:0]  wr_bytes,
    output logic                     full,
    input  wire logic                rd_en,
    output logic                     rd_valid,
    output ascp_pkg::job_meta_t      rd_meta,
    output logic [BYTES_W-1:0]       rd_bytes
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ascp_pkg::job_meta_t meta_mem [DEPTH];
    logic [BYTES_W-1:0]  bytes_mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_meta  = meta_mem[rd_ptr_reg];
    assign rd_bytes = bytes_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            meta_mem[wr_ptr_reg]  <= wr_meta;
            bytes_mem[wr_ptr_reg] <= wr_bytes;
        end
    end

    `ASCP_ASSERT_NOW(a_no_pop_empty, rd_en, count_reg != '0, "job pop while queue empty")
    `ASCP_ASSERT_NOW(a_no_push_full, wr_en, count_reg != CNT_W'(DEPTH), "job push while full")
    `ASCP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "job count overflow")

endmodule

`default_nettype wire

### rtl/core/ascp_back.sv
// ANSI SGR color parser emitter: walks each job's held bytes and tail char
// into the result register, one per cycle unless pop stalls. Needs ascp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_sgr_color_parser_core_defines.svh"

module ascp_back #(
    parameter int BUF_LEN = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_valid,
    input  ascp_pkg::job_meta_t       rd_meta,
    input  wire logic [BUF_LEN*8-1:0] rd_bytes,
    output logic                      rd_en,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [7:0]                char_code,
    output logic [15:0]               color_attr,
    output logic [15:0]               cell_word,
    output logic                      last
);

    localparam int IDX_W = $clog2(BUF_LEN);
    localparam int HW    = ascp_pkg::HELD_W;

    logic [HW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    char_reg;
    logic [15:0]   color_reg;
    logic [15:0]   cell_reg;
    logic          last_reg;

    logic [7:0]    byte_arr [BUF_LEN];
    logic          advance;
    logic          at_tail;
    logic [7:0]    sel_char;

    always_comb
    begin
        for (int i = 0; i < BUF_LEN; i++) begin
            byte_arr[i] = rd_bytes[i*8 +: 8];
        end
    end

    // Advance when a job is waiting and the result slot is free or draining.
    assign advance  = rd_valid && (!out_valid_reg || pop);
    assign at_tail  = (idx_reg == rd_meta.held);
    assign sel_char = at_tail ? rd_meta.tail : byte_arr[idx_reg[IDX_W-1:0]];
    assign rd_en    = advance && at_tail;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            idx_next       = at_tail ? '0 : idx_reg + HW'(1);
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            char_reg  <= sel_char;
            color_reg <= rd_meta.color;
            cell_reg  <= {rd_meta.color[15:8], rd_meta.color[7:0] | sel_char};
            last_reg  <= at_tail;
        end
    end

    assign empty      = !out_valid_reg;
    assign char_code  = char_reg;
    assign color_attr = color_reg;
    assign cell_word  = cell_reg;
    assign last       = last_reg;

    `ASCP_ASSERT_NOW(a_idx_bound, rd_valid, idx_reg <= rd_meta.held, "index past held bytes")
    `ASCP_ASSERT_NEXT(a_idx_rewind, rd_en, idx_reg == '0, "index not rewound after job")
    `ASCP_ASSERT_NOW(a_cell_ok, out_valid_reg, cell_reg == ({8'h00, char_reg} | color_reg),
        "cell word mismatch")

endmodule

`default_nettype wire

### rtl/core/ansi_sgr_color_parser_core.sv
// Top level of the ANSI SGR color parser: front end, job queue and emitter.
// Depends on ascp_pkg, ascp_front, ascp_job_fifo and ascp_back.
//
//   Channel   Handshake          Payload
//   --------  -----------------  -----------------------------------------------
//   input     push / full        cmd, char_byte, color_value
//   result    pop / empty        char_code, color_attr, cell_word, last
//
// Requests are taken one per cycle, back to back, while full is low; a plain
// character is registered in the job queue, then in the result register.
// A flush of n held bytes yields n+1 emitter results, one per cycle without stalls.
// Reset clears the sequence state to idle and both colors to gray.
// A stalled pop holds the result register, then the job queue; the front end
// keeps taking requests until both queue slots are occupied and full rises.
`timescale 1ns / 1ps
`default_nettype none

module ansi_sgr_color_parser_core #(
    parameter int BUF_LEN = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        cmd,
    input  wire logic [7:0]  char_byte,
    input  wire logic [15:0] color_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       char_code,
    output logic [15:0]      color_attr,
    output logic [15:0]      cell_word,
    output logic             last
);

    // job from front end into the queue
    logic                 job_push;
    ascp_pkg::job_meta_t  job_meta;
    logic [BUF_LEN*8-1:0] job_bytes;
    logic                 job_full;

    // head of the queue toward the emitter
    logic                 rd_valid;
    logic                 rd_en;
    ascp_pkg::job_meta_t  rd_meta;
    logic [BUF_LEN*8-1:0] rd_bytes;

    assign full = job_full;

    // Classify each request and update sequence state; issue emit jobs.
    ascp_front #(
        .BUF_LEN (BUF_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .job_full    (job_full),
        .cmd         (cmd),
        .char_byte   (char_byte),
        .color_value (color_value),
        .job_push    (job_push),
        .job_meta    (job_meta),
        .job_bytes   (job_bytes)
    );

    // Decouple the front end from the emitter.
    ascp_job_fifo #(
        .BYTES_W (BUF_LEN * 8)
    ) u_job_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_meta  (job_meta),
        .wr_bytes (job_bytes),
        .full     (job_full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_meta  (rd_meta),
        .rd_bytes (rd_bytes)
    );

    // Drain each job into results, oldest byte first.
    ascp_back #(
        .BUF_LEN (BUF_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_valid   (rd_valid),
        .rd_meta    (rd_meta),
        .rd_bytes   (rd_bytes),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .char_code  (char_code),
        .color_attr (color_attr),
        .cell_word  (cell_word),
        .last       (last)
    );

endmodule

`default_nettype wire

### tb/ansi_sgr_color_parser_core_test.sv
// Self-checking testbench for ansi_sgr_color_parser_core: a directed script, then
// random escape sequences and noise; checked by an in-bench predictor or by hand.
// Depends on ascp_pkg and the RTL of ansi_sgr_color_parser_core.
`timescale 1ns / 1ps

module ansi_sgr_color_parser_core_test;

    localparam int SEQ_LEN     = 8;      // byte capacity of the sequence buffer
    localparam int TOTAL_ITEMS = 450;
    localparam int NROWS       = 28;

    // One emitted console write.
    typedef struct packed {
        logic [7:0]  ch;
        logic [15:0] attr;
        logic [15:0] word;
        logic        is_last;
    } screen_write_t;

    // One row of the directed script. Rows with has_want set carry the single
    // result typed in by hand; every other row is checked against the predictor.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  ch;
        logic [15:0] color;
        logic        has_want;
        logic [7:0]  want_ch;
        logic [15:0] want_attr;
        logic [15:0] want_word;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        cmd;
    logic [7:0]  char_byte;
    logic [15:0] color_value;
    logic        empty;
    logic        pop;
    logic [7:0]  char_code;
    logic [15:0] color_attr;
    logic [15:0] cell_word;
    logic        last;

    ansi_sgr_color_parser_core #(
        .BUF_LEN(SEQ_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .char_byte(char_byte),
        .color_value(color_value),
        .empty(empty),
        .pop(pop),
        .char_code(char_code),
        .color_attr(color_attr),
        .cell_word(cell_word),
        .last(last)
    );

    // Attribute nibble for each console color index.
    logic [2:0] color_nibble [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    // Predictor state: sequence buffer, code being collected and both colors.
    logic [7:0]  seq_bytes [SEQ_LEN];
    int          seq_count;
    logic [7:0]  code_value;
    logic [15:0] pending_attr;
    logic [15:0] active_attr;

    screen_write_t writes_due[$];
    script_row_t   script [NROWS];

    int  mismatch_count = 0;
    int  requests_sent;
    int  writes_checked = 0;
    int  flush_count;
    bit  no_idle;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Allow for every request flushing a full buffer with each result
    // waiting out the longest pop stall, several times over.
    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Print one line per mismatch and count it.
    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one SGR code to a color attribute.
    function automatic logic [15:0] fold_sgr(input logic [15:0] col, input logic [7:0] code);
        logic [31:0] wide;
        logic [15:0] r;
        r = col;
        if (code == ascp_pkg::SGR_RESET)
            r = ascp_pkg::GRAY;
        else if (code == ascp_pkg::SGR_BRIGHT)
            r = col | ascp_pkg::BRIGHT_FG;
        else if (code == ascp_pkg::SGR_DIM)
            r = col & ~ascp_pkg::BRIGHT_FG;
        else if (code == ascp_pkg::SGR_SWAP)
        begin
            // OR of nibble shifts in a 32-bit word; keep the upper byte only.
            wide = ({16'h0000, col} >> 4) | ({16'h0000, col} << 4);
            r = wide[15:0] & ascp_pkg::SWAP_MASK;
        end
        else if (code >= ascp_pkg::SGR_FG
                 && code <= ascp_pkg::SGR_FG + ascp_pkg::SGR_SPAN)
            r = (col & ascp_pkg::KEEP_BG)
                | {5'd0, color_nibble[3'(code - ascp_pkg::SGR_FG)], 8'h00};
        else if (code >= ascp_pkg::SGR_BG
                 && code <= ascp_pkg::SGR_BG + ascp_pkg::SGR_SPAN)
            r = (col & ascp_pkg::KEEP_FG)
                | {1'b0, color_nibble[3'(code - ascp_pkg::SGR_BG)], 12'h000};
        else if (code >= ascp_pkg::SGR_FG_HI
                 && code <= ascp_pkg::SGR_FG_HI + ascp_pkg::SGR_SPAN)
            r = (col & ascp_pkg::KEEP_BG)
                | {5'd0, color_nibble[3'(code - ascp_pkg::SGR_FG_HI)], 8'h00}
                | ascp_pkg::BRIGHT_FG;
        else if (code >= ascp_pkg::SGR_BG_HI
                 && code <= ascp_pkg::SGR_BG_HI + ascp_pkg::SGR_SPAN)
            r = (col & ascp_pkg::KEEP_FG)
                | {1'b0, color_nibble[3'(code - ascp_pkg::SGR_BG_HI)], 12'h000}
                | ascp_pkg::BRIGHT_BG;
        return r;
    endfunction

    // Queue one console write with the color in force now.
    function automatic void queue_write(input logic [7:0] ch, input logic fin);
        screen_write_t w;
        w.ch      = ch;
        w.attr    = active_attr;
        w.word    = {8'h00, ch} | active_attr;
        w.is_last = fin;
        writes_due.push_back(w);
    endfunction

    // Advance the parser model by one accepted request and queue its writes.
    function automatic void parse_console_byte(input logic c_cmd, input logic [7:0] c,
                                               input logic [15:0] col);
        int  n;
        int  len;
        int  v;
        bit  is_digit;
        if (c_cmd)
        begin
            active_attr = col;
            return;
        end

        n = seq_count;
        if (n == 0 || n >= SEQ_LEN)
        begin
            if (n >= SEQ_LEN)
            begin
                seq_count  = 0;
                code_value = 8'd0;
            end
            if (c != ascp_pkg::ESC_CHAR)
            begin
                queue_write(c, 1'b1);
                return;
            end
            seq_bytes[0] = c;
            seq_count    = 1;
            return;
        end

        seq_bytes[n] = c;
        len          = n + 1;
        is_digit     = (c >= ascp_pkg::CHAR_0 && c <= ascp_pkg::CHAR_9);

        if (len == 2 && c == ascp_pkg::LBRACKET)
        begin
            pending_attr = ascp_pkg::GRAY;
            code_value   = 8'd0;
            seq_count    = len;
            return;
        end
        if (len > 2 && len < SEQ_LEN && (is_digit || c == ascp_pkg::SEMICOLON))
        begin
            if (is_digit)
            begin
                v = code_value * 10 + (c - ascp_pkg::CHAR_0);
                code_value = (v > 255) ? 8'd255 : v[7:0];
            end
            else
            begin
                pending_attr = fold_sgr(pending_attr, code_value);
                code_value   = 8'd0;
            end
            seq_count = len;
            return;
        end
        if (c == ascp_pkg::CHAR_M)
        begin
            if (len == 2)
                active_attr = ascp_pkg::GRAY;
            else
                active_attr = fold_sgr(pending_attr, code_value);
            seq_count  = 0;
            code_value = 8'd0;
            return;
        end

        // Anything else dumps the held bytes, then this one, as plain text.
        flush_count++;
        for (int i = 0; i < len; i++)
            queue_write(seq_bytes[i], (i + 1 == len));
        seq_count  = 0;
        code_value = 8'd0;
    endfunction

    // Drive one request, hold it until accepted, then predict its writes.
    // Push stays high across back-to-back requests so it never toggles
    // twice in one time step.
    task automatic send_request(input logic c_cmd, input logic [7:0] c,
                                input logic [15:0] col);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        cmd         <= c_cmd;
        char_byte   <= c;
        color_value <= col;
        do
            @(posedge clk);
        while (full !== 1'b0);
        requests_sent++;
        parse_console_byte(c_cmd, c, col);
    endtask

    // Character request; the unused color field carries random bits.
    task automatic send_char(input logic [7:0] c);
        send_request(1'b0, c, 16'($urandom));
    endtask

    // Color command request, now and then at an extreme value.
    task automatic send_color();
        int r;
        logic [15:0] col;
        r = $urandom_range(0, 9);
        col = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        send_request(1'b1, 8'($urandom), col);
    endtask

    // Send a code as decimal digits.
    task automatic send_number(input int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Pick an SGR code: mostly meaningful ones, some unused, some that saturate.
    function automatic int pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return ascp_pkg::SGR_RESET;
        if (r < 14)
            return ascp_pkg::SGR_BRIGHT;
        if (r < 20)
            return ascp_pkg::SGR_DIM;
        if (r < 28)
            return ascp_pkg::SGR_SWAP;
        if (r < 42)
            return ascp_pkg::SGR_FG + $urandom_range(0, 7);
        if (r < 56)
            return ascp_pkg::SGR_BG + $urandom_range(0, 7);
        if (r < 70)
            return ascp_pkg::SGR_FG_HI + $urandom_range(0, 7);
        if (r < 84)
            return ascp_pkg::SGR_BG_HI + $urandom_range(0, 7);
        if (r < 93)
            return $urandom_range(0, 255);
        return $urandom_range(256, 999);
    endfunction

    // Noise byte for broken sequences: sequence syntax mixed with anything.
    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return ascp_pkg::LBRACKET;
            1: return ascp_pkg::SEMICOLON;
            2: return ascp_pkg::CHAR_M;
            3: return ascp_pkg::ESC_CHAR;
            4: return 8'(ascp_pkg::CHAR_0 + $urandom_range(0, 9));
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random pop stalls, and the check of every write taken
    // ------------------------------------------------------------------
    int pop_stall;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            pop_stall  = 0;
        end
        else if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall--;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                pop_stall = idle_len();
        end
    end

    // Signals read here hold their values from before this edge.
    always @(posedge clk)
    begin
        screen_write_t want;
        if (rst_n && pop && !empty)
        begin
            writes_checked++;
            if (writes_due.size() == 0)
                flag_mismatch($sformatf("write %h/%h with nothing expected",
                                        char_code, color_attr));
            else
            begin
                want = writes_due.pop_front();
                if (char_code !== want.ch)
                    flag_mismatch($sformatf("char_code got %h want %h", char_code, want.ch));
                if (color_attr !== want.attr)
                    flag_mismatch($sformatf("color_attr got %h want %h",
                                            color_attr, want.attr));
                if (cell_word !== want.word)
                    flag_mismatch($sformatf("cell_word got %h want %h", cell_word, want.word));
                if (last !== want.is_last)
                    flag_mismatch($sformatf("last got %b want %b", last, want.is_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int kind;
        int ncodes;
        screen_write_t typed;

        rst_n       <= 1'b0;
        push        <= 1'b0;
        cmd         <= 1'b0;
        char_byte   <= 8'h00;
        color_value <= 16'h0000;
        no_idle        = 1'b0;
        requests_sent  = 0;
        flush_count    = 0;

        // Model state after reset: idle, both colors gray.
        seq_count    = 0;
        code_value   = 8'd0;
        pending_attr = ascp_pkg::GRAY;
        active_attr  = ascp_pkg::GRAY;

        // Directed script. Plain characters after reset and after color
        // commands at the extremes carry hand-typed results.
        script = '{
            '{1'b0, "A",                 16'h0000, 1'b1, 8'h41, 16'h0700, 16'h0741},
            '{1'b0, 8'h00,               16'h0000, 1'b1, 8'h00, 16'h0700, 16'h0700},
            '{1'b0, 8'hFF,               16'hFFFF, 1'b1, 8'hFF, 16'h0700, 16'h07FF},
            '{1'b1, 8'h00,               16'hFFFF, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, 8'h00,               16'h0000, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF},
            '{1'b1, 8'hFF,               16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            // newline is plain text: no padding
            '{1'b0, 8'h0A,               16'h0000, 1'b1, 8'h0A, 16'h0000, 16'h000A},
            // ESC m: early end back to gray
            '{1'b0, ascp_pkg::ESC_CHAR,  16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, ascp_pkg::CHAR_M,    16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "x",                 16'h0000, 1'b1, 8'h78, 16'h0700, 16'h0778},
            // code 300 saturates and has no effect; a color command in the
            // middle of a sequence leaves the sequence running
            '{1'b0, ascp_pkg::ESC_CHAR,  16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, ascp_pkg::LBRACKET,  16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "3",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "0",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "0",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b1, 8'h00,               16'h1234, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, ascp_pkg::CHAR_M,    16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            // ESC [ 107 ; 3 m: closing m lands on the last buffer slot
            '{1'b0, ascp_pkg::ESC_CHAR,  16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, ascp_pkg::LBRACKET,  16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "1",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "0",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "7",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, ascp_pkg::SEMICOLON, 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "3",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, ascp_pkg::CHAR_M,    16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            // ESC [ q: flush of the held bytes and the stray one
            '{1'b0, ascp_pkg::ESC_CHAR,  16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, ascp_pkg::LBRACKET,  16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000},
            '{1'b0, "q",                 16'h0000, 1'b0, 8'h00, 16'h0000, 16'h0000}
        };

        // Hold reset, then release it at an edge so the block still
        // sees it asserted there.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the script.
        foreach (script[i])
        begin
            send_request(script[i].cmd, script[i].ch, script[i].color);
            if (script[i].has_want)
            begin
                // A typed row yields one write: swap the predicted one for it.
                void'(writes_due.pop_back());
                typed.ch      = script[i].want_ch;
                typed.attr    = script[i].want_attr;
                typed.word    = script[i].want_word;
                typed.is_last = 1'b1;
                writes_due.push_back(typed);
            end
        end

        // Random part: mostly well-formed sequences with random codes, the
        // rest plain text, broken sequences and color commands.
        while (requests_sent < TOTAL_ITEMS)
        begin
            // Now and then run a stretch with no idling on either side.
            if ($urandom_range(0, 15) == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                send_char(ascp_pkg::ESC_CHAR);
                send_char(ascp_pkg::LBRACKET);
                ncodes = $urandom_range(0, 3);
                for (int k = 0; k < ncodes; k++)
                begin
                    if (k > 0)
                        send_char(ascp_pkg::SEMICOLON);
                    if ($urandom_range(0, 9) == 0)
                        send_color();
                    if ($urandom_range(0, 11) != 0)
                        send_number(pick_code());
                end
                send_char(ascp_pkg::CHAR_M);
            end
            else if (kind < 75)
            begin
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom));
            end
            else if (kind < 90)
            begin
                send_char(ascp_pkg::ESC_CHAR);
                repeat ($urandom_range(1, 6))
                    send_char(pick_noise());
            end
            else
                send_color();
        end
        push    <= 1'b0;
        no_idle  = 1'b0;

        // Drain, then give the block time to show any stray write.
        while (writes_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("covered %0d requests and %0d console writes, %0d of them flushes",
                 requests_sent, writes_checked, flush_count);
        $display("mismatches seen: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ascp_pkg.sv
rtl/core/ascp_front.sv
rtl/core/ascp_job_fifo.sv
rtl/core/ascp_back.sv
rtl/core/ansi_sgr_color_parser_core.sv
tb/ansi_sgr_color_parser_core_test.sv
